>>> rtl/range_min_segment_tree_macros.svh
// Assertion macros for the range minimum segment tree checker.
// Depends on nothing; included by the checker file.
`ifndef RANGE_MIN_SEGMENT_TREE_MACROS_SVH
`define RANGE_MIN_SEGMENT_TREE_MACROS_SVH

// Next-cycle implication, switched off while reset is high.
`define RMST_ASSERT_NEXT(label, clk, rst, cond, result) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (result)) \
      else $error("range_min_segment_tree: next-cycle property failed");

// Next-cycle implication that also holds across reset.
`define RMST_ASSERT_NEXT_ALWAYS(label, clk, cond, result) \
   label: assert property (@(posedge clk) (cond) |=> (result)) \
      else $error("range_min_segment_tree: reset property failed");

`endif

>>> rtl/rmst_pkg.sv
// Types and constants of the range minimum segment tree.
// Used by the top level and by its port checker; depends on nothing.
package rmst_pkg;

   localparam int POS_W       = 11;
   localparam int VAL_W       = 32;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 32;

   localparam logic [VAL_W-1:0] EMPTY_MARK      = 32'h003f_3f3f;
   localparam logic [VAL_W-1:0] BEST_START      = 32'hffff_ffff;
   localparam logic [POS_W-1:0] USED_SIZE_RESET = 11'd1024;

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE_LEAF,
      ST_UPDATE_MERGE,
      ST_QUERY_LEFT,
      ST_QUERY_RIGHT,
      ST_QUERY_DONE
   } state_type;

endpackage

>>> rtl/range_min_segment_tree.sv
// Range minimum table kept as a bottom-up binary segment tree in one RAM.
// Depends on rmst_pkg and rmst_ram.
//
// Channel   Direction  Handshake                 Contents
// req_      in         req_tvalid / req_tready   tuser: op; tdata: position, value,
//                                                range_low, range_high
// rsp_      out        rsp_tvalid / rsp_tready   tdata: min_value (queries only)
// csr_      in         csr_valid / csr_ready     used_size
//
// Requests are handled one at a time. An update walks from the leaf up to the root, one tree
// level at a time, since the single RAM read port fetches one sibling per level.
// A query walks up from both boundaries of the range: each level of the walk visits the left
// boundary and then the right one, again bounded by the one read port.
// After reset the tree is cleared by a pass that writes the empty sentinel into every node;
// req_tready stays low during it, csr writes are taken as usual.
// A finished query waits in the output register, so a new request can be taken while
// rsp_tready is low; only a second query result stalls until the first one is taken.
module range_min_segment_tree
   import rmst_pkg::*;
#(
   parameter int MAX_POSITIONS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,   // [0] op
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [10:0] position, [42:11] value,
                                               // [53:43] range_low, [64:54] range_high,
                                               // [71:65] zero
   // Response channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [31:0] min_value
   // Configuration write channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [POS_W-1:0]       csr_data     // used_size
);

   // Node index width, walk bound width (one more, the right end may reach 2 * MAX_POSITIONS)
   // and a common width for all comparisons against the table size.
   localparam int NODES = 2 * MAX_POSITIONS;
   localparam int IW    = $clog2(NODES);
   localparam int RW    = IW + 1;
   localparam int CW    = (RW > POS_W) ? RW : POS_W;

   localparam logic [CW-1:0] MAX_C    = CW'(MAX_POSITIONS);
   localparam logic [CW-1:0] ONE_C    = CW'(1);
   localparam logic [IW-1:0] ROOT     = IW'(1);
   localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);

   // Request fields.
   op_type           req_op;
   logic [POS_W-1:0] req_position;
   logic [VAL_W-1:0] req_value;
   logic [POS_W-1:0] req_range_low;
   logic [POS_W-1:0] req_range_high;

   assign req_op         = op_type'(req_tuser);
   assign req_position   = req_tdata[10:0];
   assign req_value      = req_tdata[42:11];
   assign req_range_low  = req_tdata[53:43];
   assign req_range_high = req_tdata[64:54];

   // Registers.
   state_type        state_ff, state_in;
   logic [POS_W-1:0] used_size_ff;
   logic [IW-1:0]    clr_ff, clr_in;
   logic [IW-1:0]    node_ff, node_in;
   logic [VAL_W-1:0] carry_ff, carry_in;
   logic [RW-1:0]    l_ff, l_in;
   logic [RW-1:0]    r_ff, r_in;
   logic [VAL_W-1:0] best_ff, best_in;
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_data_ff, rsp_data_in;

   // RAM ports.
   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   logic [VAL_W-1:0] wr_data;
   logic             rd_en;
   logic [IW-1:0]    rd_addr;
   logic [VAL_W-1:0] rd_data;

   // Size and range clipping, all at the common width.
   logic [CW-1:0]    used_ext;
   logic [CW-1:0]    eff_size;
   logic [CW-1:0]    pos_ext;
   logic [CW-1:0]    leaf_sum;
   logic             upd_ok;
   logic [CW-1:0]    lo_ext;
   logic [CW-1:0]    hi_ext;
   logic [CW-1:0]    lo_clip;
   logic [CW-1:0]    hi_clip;
   logic [CW-1:0]    l_start;
   logic [CW-1:0]    r_start;
   logic             range_empty;

   logic             req_fire;
   logic             rsp_free;
   logic [IW-1:0]    parent;
   logic [VAL_W-1:0] merged;
   logic [RW-1:0]    r_dec;

   assign used_ext    = CW'(used_size_ff);
   assign eff_size    = (used_ext > MAX_C) ? MAX_C : used_ext;
   assign pos_ext     = CW'(req_position);
   assign upd_ok      = (pos_ext != '0) && (pos_ext <= eff_size);
   assign leaf_sum    = MAX_C + pos_ext - ONE_C;
   assign lo_ext      = CW'(req_range_low);
   assign hi_ext      = CW'(req_range_high);
   assign lo_clip     = (lo_ext == '0) ? ONE_C : lo_ext;
   assign hi_clip     = (hi_ext > eff_size) ? eff_size : hi_ext;
   assign range_empty = lo_clip > hi_clip;
   assign l_start     = MAX_C + lo_clip - ONE_C;
   assign r_start     = MAX_C + hi_clip;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // During an update the walk carries the minimum of the subtree just written, so each level
   // needs only the sibling from the RAM; the parent write and the next sibling read never
   // touch the same node.
   assign parent = node_ff >> 1;
   assign merged = (rd_data < carry_ff) ? rd_data : carry_ff;
   assign r_dec  = r_ff - RW'(1);

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         used_size_ff <= USED_SIZE_RESET;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            used_size_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      carry_ff    <= carry_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      node_in      = node_ff;
      carry_in     = carry_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      pend_in      = 1'b0;
      // A read issued last cycle lands in the running minimum now.
      best_in      = (pend_ff && (rd_data < best_ff)) ? rd_data : best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = node_ff;
      wr_data      = carry_ff;
      rd_en        = 1'b0;
      rd_addr      = node_ff ^ ROOT;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = EMPTY_MARK;
            clr_in  = clr_ff + IW'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_op == OP_UPDATE) begin
                  // An update outside the table is dropped here.
                  if (upd_ok) begin
                     node_in  = leaf_sum[IW-1:0];
                     carry_in = req_value;
                     state_in = ST_UPDATE_LEAF;
                  end
               end else begin
                  l_in    = l_start[RW-1:0];
                  r_in    = r_start[RW-1:0];
                  best_in = BEST_START;
                  if (range_empty) begin
                     best_in  = EMPTY_MARK;
                     state_in = ST_QUERY_DONE;
                  end else begin
                     state_in = ST_QUERY_LEFT;
                  end
               end
            end
         end
         ST_UPDATE_LEAF: begin
            wr_en    = 1'b1;
            wr_addr  = node_ff;
            wr_data  = carry_ff;
            rd_en    = 1'b1;
            rd_addr  = node_ff ^ ROOT;
            state_in = ST_UPDATE_MERGE;
         end
         ST_UPDATE_MERGE: begin
            wr_en    = 1'b1;
            wr_addr  = parent;
            wr_data  = merged;
            carry_in = merged;
            node_in  = parent;
            if (parent == ROOT) begin
               state_in = ST_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = parent ^ ROOT;
            end
         end
         ST_QUERY_LEFT: begin
            // Top of the half-open walk over [l, r).
            if (l_ff >= r_ff) begin
               state_in = ST_QUERY_DONE;
            end else begin
               if (l_ff[0]) begin
                  rd_en   = 1'b1;
                  rd_addr = l_ff[IW-1:0];
                  pend_in = 1'b1;
                  l_in    = l_ff + RW'(1);
               end
               state_in = ST_QUERY_RIGHT;
            end
         end
         ST_QUERY_RIGHT: begin
            if (r_ff[0]) begin
               rd_en   = 1'b1;
               rd_addr = r_dec[IW-1:0];
               pend_in = 1'b1;
            end
            l_in     = l_ff >> 1;
            r_in     = r_ff >> 1;
            state_in = ST_QUERY_LEFT;
         end
         ST_QUERY_DONE: begin
            // The last read was folded in on the way here; wait for the output register.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = best_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   rmst_ram #(
      .WIDTH (VAL_W),
      .DEPTH (NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/rmst_ram.sv
// Generic single-clock RAM: one write port and one read port with registered read data.
// Depends on nothing.
module rmst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/rmst_checker.sv
// Port checker for the range minimum segment tree, bound to the top level.
// Depends on rmst_pkg and range_min_segment_tree_macros.svh.
`include "range_min_segment_tree_macros.svh"

module rmst_checker
   import rmst_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic req_fire;
   logic upd_fire;
   logic qry_fire;

   assign req_fire = req_tvalid && req_tready;
   assign upd_fire = req_fire && (op_type'(req_tuser) == OP_UPDATE);
   assign qry_fire = req_fire && (op_type'(req_tuser) == OP_QUERY);

   // The tree clear after reset keeps requests out.
   `RMST_ASSERT_NEXT_ALWAYS(a_clear_blocks, clock, reset, !req_tready)

   // A query always occupies the block for at least the next cycle.
   `RMST_ASSERT_NEXT(a_query_busy, clock, reset, qry_fire, !req_tready)

   // An update never produces a response.
   `RMST_ASSERT_NEXT(a_update_silent, clock, reset, upd_fire, !$rose(rsp_tvalid))

   // A stalled response holds.
   `RMST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))

endmodule

bind range_min_segment_tree rmst_checker u_rmst_checker (.*);

>>> test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for range_min_segment_tree: point updates and range-minimum queries.
// Depends on rmst_pkg and the range_min_segment_tree RTL; holds its own model of the table.
module tb;
   import rmst_pkg::*;

   localparam int TREE_SIZE     = 1024;
   localparam int SETTLE_CYCLES = 40;    // longer than the slowest update or query walk
   localparam int STALL_LIMIT   = 10000; // covers the clearing pass and the long hold-off
   localparam int LONG_HOLD     = 300;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic                   req_tuser  = 1'b0; // [0] op
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // [10:0] position, [42:11] value,
                                              // [53:43] range_low, [64:54] range_high
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // [31:0] min_value
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [POS_W-1:0]       csr_data   = '0;   // used_size

   // Model of the table: the value held at each position and the size register.
   logic [VAL_W-1:0] held_value [1:TREE_SIZE];
   int unsigned      table_size;
   logic [VAL_W-1:0] pending_minimums [$];

   int unsigned error_count = 0;
   int unsigned burst_left  = 0;
   int unsigned hold_cycles = 0;

   range_min_segment_tree #(
      .MAX_POSITIONS(TREE_SIZE)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned effective_size();
      return (table_size > TREE_SIZE) ? TREE_SIZE : table_size;
   endfunction

   function automatic void store_position(int unsigned pos, logic [VAL_W-1:0] val);
      if (pos >= 1 && pos <= effective_size()) begin
         held_value[pos] = val;
      end
   endfunction

   // True minimum over the clipped range, or the empty mark when nothing is left.
   function automatic logic [VAL_W-1:0] range_minimum(int unsigned lo, int unsigned hi);
      int unsigned      first;
      int unsigned      last;
      int unsigned      p;
      logic [VAL_W-1:0] best;
      first = (lo < 1) ? 1 : lo;
      last  = (hi > effective_size()) ? effective_size() : hi;
      if (first > last) begin
         return EMPTY_MARK;
      end
      best = held_value[first];
      for (p = first + 1; p <= last; p++) begin
         if (held_value[p] < best) begin
            best = held_value[p];
         end
      end
      return best;
   endfunction

   task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                  input logic [VAL_W-1:0] want);
      $display("MISMATCH at %0t: %s, got %h, expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // Offers one request; the sender runs in bursts with idle gaps between them.
   task automatic send_request(input op_type op, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val, input logic [POS_W-1:0] lo,
                               input logic [POS_W-1:0] hi);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'b0, hi, lo, val, pos};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      burst_left--;
      if (op == OP_UPDATE) begin
         store_position(32'(pos), val);
      end else begin
         pending_minimums = {pending_minimums, range_minimum(32'(lo), 32'(hi))};
      end
   endtask

   // Stops offering, waits for every query result and lets a trailing update finish.
   task automatic drain_requests();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_minimums.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input logic [POS_W-1:0] size);
      drain_requests();
      csr_valid <= 1'b1;
      csr_data  <= size;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      table_size = 32'(size);
   endtask

   task automatic send_random_request(input int unsigned query_pct);
      int unsigned      top;
      int unsigned      pos;
      int unsigned      lo;
      int unsigned      hi;
      logic [VAL_W-1:0] val;
      op_type           op;
      top = effective_size();
      op  = ($urandom_range(0, 99) < query_pct) ? OP_QUERY : OP_UPDATE;
      pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, top + 1);
      case ($urandom_range(0, 7))
         0: val = '0;
         1: val = '1;
         2: val = EMPTY_MARK + $urandom_range(0, 2) - 1;
         3: val = $urandom_range(0, 255);
         default: val = $urandom;
      endcase
      case ($urandom_range(0, 9))
         0: begin
            lo = $urandom_range(0, 2047);
            hi = $urandom_range(0, 2047);
         end
         1, 2, 3, 4: begin
            lo = $urandom_range(0, top + 1);
            hi = lo + $urandom_range(0, 8);
         end
         default: begin
            lo = $urandom_range(0, top + 1);
            hi = $urandom_range(lo, top + 1);
         end
      endcase
      send_request(op, POS_W'(pos), val, POS_W'(lo), POS_W'(hi));
   endtask

   // A freshly cleared table answers every query with the empty mark.
   task automatic test_reset_state();
      send_request(OP_QUERY, 11'd0, 32'd0, 11'd1, 11'd1024);
      send_request(OP_QUERY, 11'd2047, 32'hffff_ffff, 11'd0, 11'd2047);
   endtask

   // Field extremes, ignored updates, clipping, empty ranges and values above the mark.
   task automatic test_field_edges();
      send_request(OP_UPDATE, 11'd1, 32'h0000_0000, 11'd0, 11'd0);
      send_request(OP_UPDATE, 11'd1024, 32'hffff_ffff, 11'd2047, 11'd2047);
      send_request(OP_UPDATE, 11'd0, 32'd5, 11'd0, 11'd0);
      send_request(OP_UPDATE, 11'd1025, 32'd6, 11'd0, 11'd0);
      send_request(OP_UPDATE, 11'd2047, 32'd7, 11'd0, 11'd0);
      send_request(OP_UPDATE, 11'd500, 32'h003f_3f40, 11'd0, 11'd0);
      send_request(OP_QUERY, 11'd0, 32'd0, 11'd0, 11'd2047);
      send_request(OP_QUERY, 11'd0, 32'd0, 11'd1024, 11'd1024);
      send_request(OP_QUERY, 11'd0, 32'd0, 11'd5, 11'd3);
      send_request(OP_QUERY, 11'd0, 32'd0, 11'd2047, 11'd2047);
      send_request(OP_QUERY, 11'd0, 32'd0, 11'd2, 11'd1023);
      send_request(OP_UPDATE, 11'd2, 32'h003f_3f3e, 11'd0, 11'd0);
      send_request(OP_QUERY, 11'd0, 32'd0, 11'd2, 11'd1023);
   endtask

   // Shrinking hides positions without losing them; zero empties the table and any
   // size above the tree acts as the full tree.
   task automatic test_size_changes();
      write_size(11'd10);
      send_request(OP_QUERY, 11'd0, 32'd0, 11'd0, 11'd2047);
      send_request(OP_UPDATE, 11'd11, 32'd0, 11'd0, 11'd0);
      send_request(OP_UPDATE, 11'd10, 32'd3, 11'd0, 11'd0);
      send_request(OP_QUERY, 11'd0, 32'd0, 11'd2, 11'd2047);
      write_size(11'd0);
      send_request(OP_UPDATE, 11'd1, 32'd9, 11'd0, 11'd0);
      send_request(OP_QUERY, 11'd0, 32'd0, 11'd0, 11'd2047);
      write_size(11'd2047);
      send_request(OP_QUERY, 11'd0, 32'd0, 11'd1024, 11'd2047);
      write_size(11'd1);
      send_request(OP_QUERY, 11'd0, 32'd0, 11'd0, 11'd2047);
   endtask

   // The receiver holds off while the sender keeps offering, so the block must stall.
   task automatic test_backpressure();
      int unsigned n;
      write_size(11'd64);
      hold_cycles = LONG_HOLD;
      burst_left  = 40;
      for (n = 0; n < 24; n++) begin
         send_random_request(70);
      end
      drain_requests();
   endtask

   task automatic test_random_traffic();
      int unsigned sizes [9] = '{1024, 1, 2, 16, 100, 0, 2047, 1000, 0};
      int unsigned items [9] = '{500, 60, 80, 300, 300, 60, 200, 200, 250};
      int unsigned i;
      for (i = 0; i < 9; i++) begin
         write_size(POS_W'((i == 8) ? $urandom_range(3, 1023) : sizes[i]));
         repeat (items[i]) send_random_request(45);
      end
      write_size(11'd1024);
   endtask

   // The receiver stalls on a ready pattern that it keeps redrawing at random; an all-ones pattern
   // gives stretches with no stall at all. A requested hold-off takes precedence.
   initial begin : response_sink
      int unsigned slot;
      logic [15:0] ready_mask;
      slot       = 0;
      ready_mask = '1;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else begin
            if (slot % 64 == 0) begin
               case ($urandom_range(0, 3))
                  0: ready_mask = '1;
                  1: ready_mask = 16'($urandom);
                  2: ready_mask = 16'($urandom | $urandom);
                  default: ready_mask = 16'($urandom & $urandom);
               endcase
            end
            rsp_tready <= ready_mask[slot % 16];
            slot++;
         end
      end
   end

   // Each accepted result is matched against the oldest outstanding query.
   initial begin : result_check
      logic [VAL_W-1:0] want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            if (pending_minimums.size() == 0) begin
               report_mismatch("result with no outstanding query", rsp_tdata, EMPTY_MARK);
            end else begin
               want = pending_minimums.pop_front();
               if (rsp_tdata[31:0] !== want) begin
                  report_mismatch("min_value", rsp_tdata[31:0], want);
               end
            end
         end
      end
   end

   // Ends the run when no request, result or register write moves for too long.
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) === 1'b1 || (rsp_tvalid && rsp_tready) === 1'b1 ||
             (csr_valid && csr_ready) === 1'b1) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin : run_tests
      int unsigned p;
      for (p = 1; p <= TREE_SIZE; p++) begin
         held_value[p] = EMPTY_MARK;
      end
      table_size = 32'(USED_SIZE_RESET);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_field_edges();
      test_size_changes();
      test_backpressure();
      test_random_traffic();
      drain_requests();

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/rmst_pkg.sv
rtl/rmst_ram.sv
rtl/range_min_segment_tree.sv
rtl/rmst_checker.sv
test/tb.sv
